@@ hw/rtl/twc_pkg.sv @@
// ----------------------------------------------------------------------------
// twc_pkg
// Shared types and constants for the threshold triggered window capture unit.
// ----------------------------------------------------------------------------
package twc_pkg;

   localparam int WINDOW = 11;
   localparam int HALF   = 5;

   localparam int SAMPLE_W = 16;
   localparam int STAMP_W  = 32;
   localparam int COUNT_W  = 32;
   localparam int POS_W    = 4;
   localparam int SLOT_W   = $clog2(WINDOW);

   localparam int REQ_W = ((SAMPLE_W + STAMP_W + 7) / 8) * 8;
   localparam int RSP_FIELDS_W = COUNT_W + STAMP_W + SAMPLE_W + POS_W;
   localparam int RSP_W = ((RSP_FIELDS_W + 7) / 8) * 8;

   localparam logic [SLOT_W-1:0] SLOT_LAST  = SLOT_W'(WINDOW - 1);
   localparam logic [SLOT_W-1:0] BACK_SLOT  = SLOT_W'(HALF % WINDOW);
   localparam logic [SLOT_W-1:0] WRAP_SLOT  = SLOT_W'(WINDOW - (HALF % WINDOW));
   localparam logic [COUNT_W-1:0] HALF_COUNT = COUNT_W'(HALF);

   localparam logic signed [SAMPLE_W-1:0] LEVEL_RESET = 16'sd31000;

   typedef logic [SLOT_W-1:0] slot_type;

   typedef struct packed {
      logic [STAMP_W-1:0]         stamp;
      logic signed [SAMPLE_W-1:0] sample;
   } entry_type;

   typedef struct packed {
      logic      en;
      slot_type  addr;
      entry_type data;
   } ring_wr_type;

   typedef struct packed {
      logic     en;
      slot_type addr;
   } ring_rd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CHECK,
      ST_EMIT
   } state_type;

   function automatic slot_type slot_next(input slot_type s);
      return (s == SLOT_LAST) ? '0 : s + SLOT_W'(1);
   endfunction

endpackage

@@ hw/rtl/twc_ring.sv @@
// ----------------------------------------------------------------------------
// twc_ring
// Sample and timestamp ring: one write port, one registered read port,
// write-first forwarding, per-entry valid flags so unwritten entries read zero.
// ----------------------------------------------------------------------------
module twc_ring (
   input  logic                 clock,
   input  logic                 reset,
   input  twc_pkg::ring_wr_type wr,
   input  twc_pkg::ring_rd_type rd,
   output twc_pkg::entry_type   rd_data
);
   import twc_pkg::*;

   entry_type         mem [WINDOW];
   logic [WINDOW-1:0] valid_ff;
   entry_type         rd_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr.en) begin
         valid_ff[wr.addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd.en) begin
         if (wr.en && (wr.addr == rd.addr)) begin
            rd_data_ff <= wr.data;
         end else if (valid_ff[rd.addr]) begin
            rd_data_ff <= mem[rd.addr];
         end else begin
            rd_data_ff <= '0;
         end
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hw/rtl/twc_ctrl.sv @@
// ----------------------------------------------------------------------------
// twc_ctrl
// Sequencer: writes each sample, reads back the center, and on a trigger
// walks the ring oldest to newest into the result register.
// ----------------------------------------------------------------------------
module twc_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [twc_pkg::REQ_W-1:0]   req_tdata,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [twc_pkg::RSP_W-1:0]   rsp_tdata,
   output logic                        rsp_tlast,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [twc_pkg::SAMPLE_W-1:0] csr_data,
   output twc_pkg::ring_wr_type        ring_wr,
   output twc_pkg::ring_rd_type        ring_rd,
   input  twc_pkg::entry_type          ring_data
);
   import twc_pkg::*;

   state_type                  state_ff, state_in;
   slot_type                   write_slot_ff, write_slot_in;
   logic [COUNT_W-1:0]         seen_ff, seen_in;
   logic signed [SAMPLE_W-1:0] level_ff;
   slot_type                   slot_ff, slot_in;
   slot_type                   pos_ff, pos_in;
   logic [COUNT_W-1:0]         trig_num_ff, trig_num_in;
   logic [STAMP_W-1:0]         trig_time_ff, trig_time_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic                       rsp_load;
   logic [RSP_W-1:0]           rsp_data_ff;
   logic                       rsp_last_ff;
   logic                       out_free;
   slot_type                   center;

   assign csr_ready = 1'b1;
   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign center    = (write_slot_ff >= BACK_SLOT) ? (write_slot_ff - BACK_SLOT)
                                                   : (write_slot_ff + WRAP_SLOT);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         write_slot_ff <= '0;
         seen_ff       <= '0;
         level_ff      <= LEVEL_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         write_slot_ff <= write_slot_in;
         seen_ff       <= seen_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_valid) begin
            level_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      slot_ff      <= slot_in;
      pos_ff       <= pos_in;
      trig_num_ff  <= trig_num_in;
      trig_time_ff <= trig_time_in;
      if (rsp_load) begin
         rsp_data_ff <= RSP_W'({POS_W'(pos_ff), ring_data.sample, trig_time_ff, trig_num_ff});
         rsp_last_ff <= (pos_ff == SLOT_LAST);
      end
   end

   always_comb begin
      state_in      = state_ff;
      write_slot_in = write_slot_ff;
      seen_in       = seen_ff;
      slot_in       = slot_ff;
      pos_in        = pos_ff;
      trig_num_in   = trig_num_ff;
      trig_time_in  = trig_time_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_load      = 1'b0;
      req_tready    = 1'b0;
      ring_wr       = '0;
      ring_rd       = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               ring_wr.en          = 1'b1;
               ring_wr.addr        = write_slot_ff;
               ring_wr.data.sample = req_tdata[SAMPLE_W-1:0];
               ring_wr.data.stamp  = req_tdata[SAMPLE_W +: STAMP_W];
               ring_rd.en          = 1'b1;
               ring_rd.addr        = center;
               write_slot_in       = slot_next(write_slot_ff);
               seen_in             = seen_ff + COUNT_W'(1);
               state_in            = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (ring_data.sample > level_ff) begin
               trig_num_in  = seen_ff - HALF_COUNT;
               trig_time_in = ring_data.stamp;
               ring_rd.en   = 1'b1;
               ring_rd.addr = write_slot_ff;
               slot_in      = write_slot_ff;
               pos_in       = '0;
               state_in     = ST_EMIT;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_load     = 1'b1;
               rsp_valid_in = 1'b1;
               if (pos_ff == SLOT_LAST) begin
                  state_in = ST_IDLE;
               end else begin
                  ring_rd.en   = 1'b1;
                  ring_rd.addr = slot_next(slot_ff);
                  slot_in      = slot_next(slot_ff);
                  pos_in       = pos_ff + SLOT_W'(1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

@@ hw/rtl/threshold_triggered_window_capture_unit.sv @@
// ----------------------------------------------------------------------------
// threshold_triggered_window_capture_unit
// Pretrigger/posttrigger capture: stores each sample in a ring and, when the
// sample HALF transactions back exceeds the level, streams out the window.
// ----------------------------------------------------------------------------
// Each request transaction writes the ring and reads the center entry in
// ST_IDLE, then compares it in ST_CHECK. On a trigger the window follows at
// one result per cycle while the output register is free (rsp_tready high),
// read through the ring's single read port.
// The last result waits in an output register while the next request is taken.
// Ring entries carry valid flags cleared by reset, so there is no clearing pass.
module threshold_triggered_window_capture_unit (
   input  logic                          clock,
   input  logic                          reset,
   // sample[15:0], timestamp[47:16]
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [twc_pkg::REQ_W-1:0]     req_tdata,
   // trigger_number[31:0], trigger_time[63:32], window_sample[79:64],
   // position[83:80], zero fill above
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [twc_pkg::RSP_W-1:0]     rsp_tdata,
   output logic                          rsp_tlast,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [twc_pkg::SAMPLE_W-1:0]  csr_data
);
   import twc_pkg::*;

   ring_wr_type ring_wr;
   ring_rd_type ring_rd;
   entry_type   ring_data;

   twc_ring u_ring (
      .clock   (clock),
      .reset   (reset),
      .wr      (ring_wr),
      .rd      (ring_rd),
      .rd_data (ring_data)
   );

   twc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .ring_wr    (ring_wr),
      .ring_rd    (ring_rd),
      .ring_data  (ring_data)
   );

endmodule
